/* rtl/e2r_pkg.sv */
// Shared types, constants and CORDIC step for the Euler-to-rotation-matrix block.
package e2r_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int COEF_BITS_DEF   = 16;
  localparam int CORDIC_ITERS    = 24;
  localparam int ITERS_PER_STAGE = 3;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;

  localparam logic [63:0]        HALFPI_Q30 = 64'd1686629713;
  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         q;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  function automatic logic signed [32:0] atan_q30(int unsigned i);
    logic signed [32:0] a;
    case (i)
      0:  a = 33'sh03243F6A8;
      1:  a = 33'sh01DAC6705;
      2:  a = 33'sh00FADBAFC;
      3:  a = 33'sh007F56EA6;
      4:  a = 33'sh003FEAB76;
      5:  a = 33'sh001FFD55B;
      6:  a = 33'sh000FFFAAA;
      7:  a = 33'sh0007FFF55;
      8:  a = 33'sh0003FFFEA;
      9:  a = 33'sh0001FFFFD;
      10: a = 33'sh0000FFFFF;
      11: a = 33'sh00007FFFF;
      12: a = 33'sh00003FFFF;
      13: a = 33'sh00001FFFF;
      14: a = 33'sh00000FFFF;
      15: a = 33'sh000007FFF;
      16: a = 33'sh000003FFF;
      17: a = 33'sh000001FFF;
      18: a = 33'sh000000FFF;
      19: a = 33'sh0000007FF;
      20: a = 33'sh0000003FF;
      21: a = 33'sh0000001FF;
      22: a = 33'sh0000000FF;
      23: a = 33'sh00000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

  // One rotation-mode step; arithmetic shifts floor like the spec.
  function automatic cordic_t cordic_iter(cordic_t c, int unsigned i);
    cordic_t            n;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    n  = c;
    if (!c.z[32]) begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - atan_q30(i);
    end else begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + atan_q30(i);
    end
    return n;
  endfunction

endpackage

/* rtl/euler_to_rotation_matrix.sv */
// Z-Y-X Euler angles to rotation matrix, fully pipelined.
// Takes one angle triple plus position per cycle and returns the nine Q1.(COEF_BITS-1)
// coefficients of the Z-Y-X rotation matrix (x, y and z basis axes) with the position
// copied through. The pipe runs through a stage for the quadrant split and angle scaling
// multiply, eight CORDIC stages of three iterations each (three parallel engines, one per
// angle), a quadrant fold stage, two multiply stages with a rounding stage between
// them, one add stage, and the round/saturate output register. Throughput is one item
// per cycle; the whole pipe advances together whenever the output register is empty or
// being taken, so out_ready low on a full output register freezes every stage and
// in_ready follows it. No state is kept between items; reset only clears the stage valid
// bits. Coefficients round half up and clamp, so +1.0 reads as the largest positive code.
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
  parameter int COEF_BITS  = e2r_pkg::COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_angle_x,
  input  logic [15:0]                 in_angle_y,
  input  logic [15:0]                 in_angle_z,
  input  logic signed [31:0]          in_pos_x_in,
  input  logic signed [31:0]          in_pos_y_in,
  input  logic signed [31:0]          in_pos_z_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COEF_BITS-1:0] out_xaxis_x,
  output logic signed [COEF_BITS-1:0] out_xaxis_y,
  output logic signed [COEF_BITS-1:0] out_xaxis_z,
  output logic signed [COEF_BITS-1:0] out_yaxis_x,
  output logic signed [COEF_BITS-1:0] out_yaxis_y,
  output logic signed [COEF_BITS-1:0] out_yaxis_z,
  output logic signed [COEF_BITS-1:0] out_zaxis_x,
  output logic signed [COEF_BITS-1:0] out_zaxis_y,
  output logic signed [COEF_BITS-1:0] out_zaxis_z,
  output logic signed [31:0]          out_pos_x_out,
  output logic signed [31:0]          out_pos_y_out,
  output logic signed [31:0]          out_pos_z_out
);
  import e2r_pkg::*;

  // stage map: 0 scale, 1..8 CORDIC, 9 quadrant, 10 mul, 11 round, 12 mul, 13 add, 14 out
  localparam int ST_QUAD = CORDIC_STAGES + 1;
  localparam int ST_M1   = ST_QUAD + 1;
  localparam int ST_RND  = ST_M1 + 1;
  localparam int ST_M2   = ST_RND + 1;
  localparam int ST_ADD  = ST_M2 + 1;
  localparam int ST_OUT  = ST_ADD + 1;
  localparam int NUM_ST  = ST_OUT + 1;
  localparam int RND_SH  = 61 - COEF_BITS;
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (COEF_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -(64'sd1 <<< (COEF_BITS - 1));
  localparam logic signed [63:0] HALF30 = 64'sd1 <<< 29;

  function automatic logic signed [COEF_BITS-1:0] to_coef(logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    if (t > CMAX) t = CMAX;
    if (t < CMIN) t = CMIN;
    return t[COEF_BITS-1:0];
  endfunction

  logic adv;
  logic vld_r [NUM_ST];
  pos_t pos_r [NUM_ST];

  assign adv       = !vld_r[ST_OUT] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_ST; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NUM_ST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r[0] <= '{x: in_pos_x_in, y: in_pos_y_in, z: in_pos_z_in};
      for (int k = 1; k < NUM_ST; k++) pos_r[k] <= pos_r[k-1];
    end
  end

  // ---- stage 0: quadrant split and r * pi/2 scaling, per angle
  logic [15:0] ang_in [3];
  assign ang_in[0] = in_angle_x;
  assign ang_in[1] = in_angle_y;
  assign ang_in[2] = in_angle_z;

  cordic_t cord_r [CORDIC_STAGES+1][3];

  for (genvar a = 0; a < 3; a++) begin : g_ang
    logic [ANGLE_BITS-1:0] ang;
    logic [63:0]           prod;
    cordic_t               init_nxt;

    assign ang  = ANGLE_BITS'(ang_in[a]);
    assign prod = 64'(ang[ANGLE_BITS-3:0]) * HALFPI_Q30;

    always_comb begin
      init_nxt.x = GAIN_Q30;
      init_nxt.y = '0;
      init_nxt.z = 33'(prod >> (ANGLE_BITS - 2));
      init_nxt.q = ang[ANGLE_BITS-1:ANGLE_BITS-2];
    end

    always_ff @(posedge clk) begin
      if (adv) cord_r[0][a] <= init_nxt;
    end

    for (genvar s = 1; s <= CORDIC_STAGES; s++) begin : g_stage
      cordic_t step_nxt;
      always_comb begin
        step_nxt = cord_r[s-1][a];
        for (int j = 0; j < ITERS_PER_STAGE; j++)
          step_nxt = cordic_iter(step_nxt, (s - 1) * ITERS_PER_STAGE + j);
      end
      always_ff @(posedge clk) begin
        if (adv) cord_r[s][a] <= step_nxt;
      end
    end
  end

  // ---- quadrant fold: (c,s), (-s,c), (-c,-s), (s,-c)
  logic signed [31:0] cos_r [3];
  logic signed [31:0] sin_r [3];

  for (genvar a = 0; a < 3; a++) begin : g_quad
    cordic_t            f;
    logic signed [33:0] c_nxt;
    logic signed [33:0] s_nxt;
    assign f = cord_r[CORDIC_STAGES][a];
    always_comb begin
      case (f.q)
        2'd0:    begin c_nxt = f.x;  s_nxt = f.y;  end
        2'd1:    begin c_nxt = -f.y; s_nxt = f.x;  end
        2'd2:    begin c_nxt = -f.x; s_nxt = -f.y; end
        default: begin c_nxt = f.y;  s_nxt = -f.x; end
      endcase
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cos_r[a] <= c_nxt[31:0];
        sin_r[a] <= s_nxt[31:0];
      end
    end
  end

  // 0 = x, 1 = y, 2 = z
  logic signed [31:0] cx, sx, cy, sy, cz, sz;
  assign cx = cos_r[0];
  assign sx = sin_r[0];
  assign cy = cos_r[1];
  assign sy = sin_r[1];
  assign cz = cos_r[2];
  assign sz = sin_r[2];

  // ---- first multiply stage, Q60
  logic signed [63:0] czsy_m_r, szsy_m_r, czcy_r, szcy_r, cysx_r, cycx_r;
  logic signed [63:0] szcx_r, czcx_r, szsx_r, czsx_r;
  logic signed [31:0] sx1_r, cx1_r, sy1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      czsy_m_r <= 64'(cz) * 64'(sy);
      szsy_m_r <= 64'(sz) * 64'(sy);
      czcy_r   <= 64'(cz) * 64'(cy);
      szcy_r   <= 64'(sz) * 64'(cy);
      cysx_r   <= 64'(cy) * 64'(sx);
      cycx_r   <= 64'(cy) * 64'(cx);
      szcx_r   <= 64'(sz) * 64'(cx);
      czcx_r   <= 64'(cz) * 64'(cx);
      szsx_r   <= 64'(sz) * 64'(sx);
      czsx_r   <= 64'(cz) * 64'(sx);
      sx1_r    <= sx;
      cx1_r    <= cx;
      sy1_r    <= sy;
    end
  end

  // ---- round the partial products back to Q30; carry the rest
  logic signed [63:0] czsy_w, szsy_w;
  logic signed [31:0] czsy_r, szsy_r, sx2_r, cx2_r, sy2_r;
  logic signed [63:0] czcy2_r, szcy2_r, cysx2_r, cycx2_r, szcx2_r, czcx2_r, szsx2_r, czsx2_r;

  assign czsy_w = (czsy_m_r + HALF30) >>> 30;
  assign szsy_w = (szsy_m_r + HALF30) >>> 30;

  always_ff @(posedge clk) begin
    if (adv) begin
      czsy_r  <= czsy_w[31:0];
      szsy_r  <= szsy_w[31:0];
      sx2_r   <= sx1_r;
      cx2_r   <= cx1_r;
      sy2_r   <= sy1_r;
      czcy2_r <= czcy_r;
      szcy2_r <= szcy_r;
      cysx2_r <= cysx_r;
      cycx2_r <= cycx_r;
      szcx2_r <= szcx_r;
      czcx2_r <= czcx_r;
      szsx2_r <= szsx_r;
      czsx2_r <= czsx_r;
    end
  end

  // ---- second multiply stage
  logic signed [63:0] a1_r, a2_r, a3_r, a4_r, nsy_r;
  logic signed [63:0] czcy3_r, szcy3_r, cysx3_r, cycx3_r, szcx3_r, czcx3_r, szsx3_r, czsx3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r    <= 64'(czsy_r) * 64'(sx2_r);
      a2_r    <= 64'(szsy_r) * 64'(sx2_r);
      a3_r    <= 64'(czsy_r) * 64'(cx2_r);
      a4_r    <= 64'(szsy_r) * 64'(cx2_r);
      nsy_r   <= -(64'(sy2_r) <<< 30);
      czcy3_r <= czcy2_r;
      szcy3_r <= szcy2_r;
      cysx3_r <= cysx2_r;
      cycx3_r <= cycx2_r;
      szcx3_r <= szcx2_r;
      czcx3_r <= czcx2_r;
      szsx3_r <= szsx2_r;
      czsx3_r <= czsx2_r;
    end
  end

  // ---- add stage: nine Q60 coefficients, row-major x/y/z axis
  logic signed [63:0] q60_r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      q60_r[0] <= czcy3_r;
      q60_r[1] <= szcy3_r;
      q60_r[2] <= nsy_r;
      q60_r[3] <= a1_r - szcx3_r;
      q60_r[4] <= a2_r + czcx3_r;
      q60_r[5] <= cysx3_r;
      q60_r[6] <= a3_r + szsx3_r;
      q60_r[7] <= a4_r - czsx3_r;
      q60_r[8] <= cycx3_r;
    end
  end

  // ---- output register: round half up and saturate
  logic signed [COEF_BITS-1:0] coef_r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) coef_r[k] <= to_coef(q60_r[k]);
    end
  end

  assign out_xaxis_x   = coef_r[0];
  assign out_xaxis_y   = coef_r[1];
  assign out_xaxis_z   = coef_r[2];
  assign out_yaxis_x   = coef_r[3];
  assign out_yaxis_y   = coef_r[4];
  assign out_yaxis_z   = coef_r[5];
  assign out_zaxis_x   = coef_r[6];
  assign out_zaxis_y   = coef_r[7];
  assign out_zaxis_z   = coef_r[8];
  assign out_pos_x_out = pos_r[ST_OUT].x;
  assign out_pos_y_out = pos_r[ST_OUT].y;
  assign out_pos_z_out = pos_r[ST_OUT].z;

  // a stalled pipe holds its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (vld_r[0] == $past(vld_r[0])) && (vld_r[ST_QUAD] == $past(vld_r[ST_QUAD])))
    else $error("pipe moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted item not in first stage");

  a_last_shift: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vld_r[ST_OUT] == $past(vld_r[ST_ADD]))
    else $error("output stage lost or repeated an item");

endmodule

/* sim/testbench.sv */
// Testbench for the Z-Y-X Euler angle to rotation matrix block.
`timescale 1ns / 1ps

module testbench;
  import e2r_pkg::*;

  localparam int COEF_W  = 16;
  localparam int LIMIT   = 400000;
  localparam int LATENCY = 15;

  typedef struct {
    logic signed [COEF_W-1:0] coef [9];
    logic signed [31:0]       pos  [3];
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic signed [31:0] in_pos_x_in = '0, in_pos_y_in = '0, in_pos_z_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COEF_W-1:0] out_xaxis_x, out_xaxis_y, out_xaxis_z;
  logic signed [COEF_W-1:0] out_yaxis_x, out_yaxis_y, out_yaxis_z;
  logic signed [COEF_W-1:0] out_zaxis_x, out_zaxis_y, out_zaxis_z;
  logic signed [31:0] out_pos_x_out, out_pos_y_out, out_pos_z_out;

  matrix_t pending_matrices[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  euler_to_rotation_matrix u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Round half up on 64-bit signed values: add half, then arithmetic shift.
  function automatic longint round_q(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                  output longint s);
    longint x, y, z, dx, dy;
    longint atn [24];
    logic [63:0] r;
    atn = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
            64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    r = {50'd0, ang[13:0]};
    z = longint'((r * 64'd1686629713) >> 14);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atn[i];
      end else begin
        x += dx; y -= dy; z += atn[i];
      end
    end
    case (ang[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // Q60 to rounded, clamped Q1.15.
  function automatic logic signed [COEF_W-1:0] q60_to_coef(longint v60);
    longint v;
    v = round_q(v60, 60 - (COEF_W - 1));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COEF_W-1:0];
  endfunction

  function automatic matrix_t rotation_of(logic [15:0] ax, logic [15:0] ay,
                                          logic [15:0] az, logic signed [31:0] px,
                                          logic signed [31:0] py, logic signed [31:0] pz);
    matrix_t m;
    longint cx, sx, cy, sy, cz, sz, czsy, szsy;
    sin_cos(ax, cx, sx);
    sin_cos(ay, cy, sy);
    sin_cos(az, cz, sz);
    czsy = round_q(cz * sy, 30);
    szsy = round_q(sz * sy, 30);
    m.coef[0] = q60_to_coef(cz * cy);
    m.coef[1] = q60_to_coef(sz * cy);
    m.coef[2] = q60_to_coef(-sy * (64'sd1 <<< 30));
    m.coef[3] = q60_to_coef(czsy * sx - sz * cx);
    m.coef[4] = q60_to_coef(szsy * sx + cz * cx);
    m.coef[5] = q60_to_coef(cy * sx);
    m.coef[6] = q60_to_coef(czsy * cx + sz * sx);
    m.coef[7] = q60_to_coef(szsy * cx - cz * sx);
    m.coef[8] = q60_to_coef(cy * cx);
    m.pos = '{px, py, pz};
    return m;
  endfunction

  // Send one item; gaps before it follow send_idle_pct. Valid stays up
  // between back-to-back items, never dropped and raised in one step.
  task automatic send_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_angle_x  <= ax;
    in_angle_y  <= ay;
    in_angle_z  <= az;
    in_pos_x_in <= px;
    in_pos_y_in <= py;
    in_pos_z_in <= pz;
    pending_matrices.push_back(rotation_of(ax, ay, az, px, py, pz));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: compare against the oldest predicted matrix.
  always @(posedge clk) begin
    matrix_t exp_m;
    logic signed [COEF_W-1:0] got [9];
    logic signed [31:0] gpos [3];
    if (rst_n && out_valid && out_ready) begin
      got  = '{out_xaxis_x, out_xaxis_y, out_xaxis_z, out_yaxis_x, out_yaxis_y,
               out_yaxis_z, out_zaxis_x, out_zaxis_y, out_zaxis_z};
      gpos = '{out_pos_x_out, out_pos_y_out, out_pos_z_out};
      if (pending_matrices.size() == 0) begin
        $display("%0t: unexpected result item", $time);
        errors++;
      end else begin
        exp_m = pending_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== exp_m.coef[k]) begin
            $display("%0t: coef %0d expected %0d actual %0d", $time, k,
                     exp_m.coef[k], got[k]);
            errors++;
          end
        for (int k = 0; k < 3; k++)
          if (gpos[k] !== exp_m.pos[k]) begin
            $display("%0t: pos %0d expected %0d actual %0d", $time, k,
                     exp_m.pos[k], gpos[k]);
            errors++;
          end
      end
      checked++;
    end
  end

  // Quadrant edges, the +1.0 saturation case, position extremes.
  // Valid is left up at the end; the next test takes over the channel.
  task automatic test_directed();
    logic [15:0] edges [10];
    edges = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
              16'h3FFF, 16'h2000, 16'h0001, 16'hAAAA, 16'h5555};
    send_angles(16'h0000, 16'h0000, 16'h0000, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1);
    for (int i = 0; i < 10; i++)
      send_angles(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10],
                  $urandom, $urandom, $urandom);
    // gimbal lock: pitch at +/- quarter turn
    send_angles(16'h1234, 16'h4000, 16'h5678, 32'sd1, 32'sd2, 32'sd3);
    send_angles(16'h1234, 16'hC000, 16'h5678, -32'sd1, -32'sd2, -32'sd3);
  endtask

  task automatic test_random(int n);
    logic [15:0] a [3];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++)
        case ($urandom_range(3))
          0: a[k] = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(2)) - 16'd1;
          default: a[k] = 16'($urandom);
        endcase
      send_angles(a[0], a[1], a[2], $urandom, $urandom, $urandom);
    end
    release_input();
  endtask

  task automatic drain();
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 9;  recv_idle_pct = 76;
    test_directed();
    test_random(300);
    drain();
    send_idle_pct = 76; recv_idle_pct = 9;
    test_random(300);
    drain();
    send_idle_pct = 0;  recv_idle_pct = 0;
    test_random(330);
    drain();
    $display("Sent %0d items, checked %0d result items, %0d mismatches", sent,
             checked, errors);
    $display("Covered quadrant edges, gimbal lock, saturation and three stall mixes");
    if (errors == 0 && pending_matrices.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
